// File: rtl/core/byte_level_utf8_text_decoder_unit_macros.svh
// Assertion helpers shared by the decoder RTL. Each macro expects signals
// named clock and reset in the module that uses it.
`ifndef BYTE_LEVEL_UTF8_TEXT_DECODER_UNIT_MACROS_SVH
`define BYTE_LEVEL_UTF8_TEXT_DECODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define BLDEC_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bldec assertion failed");

// Next-cycle implication.
`define BLDEC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bldec assertion failed");

`endif

// File: rtl/core/bldec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bldec_pkg;

   localparam int unsigned RUN_SLOTS = 4;

   localparam logic [1:0] KIND_MAPPED  = 2'd0;
   localparam logic [1:0] KIND_RECODED = 2'd1;
   localparam logic [1:0] KIND_RAW     = 2'd2;

   // One run of output words caused by a single input word.
   typedef struct packed {
      logic [RUN_SLOTS-1:0][7:0] bytes;
      logic [RUN_SLOTS-1:0][1:0] kinds;
      logic [1:0]                last_idx;
   } run_type;

endpackage

`default_nettype wire

// File: rtl/core/bldec_channels.sv
`timescale 1ns / 1ps
`default_nettype none

interface bldec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface bldec_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] byte_kind;
   logic       run_last;

   modport source (output valid, output out_byte, output byte_kind, output run_last,
                   input ready);
   modport sink (input valid, input out_byte, input byte_kind, input run_last,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/core/bldec_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bldec_front (
   input  wire logic        clock,
   input  wire logic        reset,
   bldec_req_if.sink        req_chan,
   output bldec_pkg::run_type push_data,
   output logic             push,
   input  wire logic        full
);
   import bldec_pkg::*;
   `include "byte_level_utf8_text_decoder_unit_macros.svh"

   logic [2:0][7:0] held_ff;
   logic [2:0][7:0] held_in;
   logic [2:0]      exp_ff;
   logic [2:0]      exp_in;
   logic [1:0]      cnt_ff;
   logic [1:0]      cnt_in;

   logic        accept;
   logic [7:0]  c;
   logic        is_cont;
   logic        is_lead;
   logic [2:0]  lead_len;
   logic        complete;
   logic        do_fresh;
   logic        ascii;
   logic        raw_one;
   logic [1:0]  a_cnt;
   logic [1:0]  c_cnt;

   logic [20:0] cp_asm;
   logic [20:0] cp;
   logic        vis8;
   logic        ctrl;
   logic [6:0]  ctrl_n;
   logic [3:0][7:0] enc_bytes;
   logic [3:0][1:0] enc_kinds;
   logic [2:0]  enc_cnt;

   logic [3:0][7:0] b_bytes;
   logic [3:0][1:0] b_kinds;
   logic [2:0]  b_cnt;
   logic [2:0]  total;

   function automatic logic visible(input logic [7:0] b);
      return (b >= 8'h21 && b <= 8'h7E) || (b >= 8'hA1 && b <= 8'hAC) || (b >= 8'hAE);
   endfunction

   function automatic logic [7:0] pick3(input logic [2:0][7:0] arr, input logic [1:0] idx);
      logic [7:0] r;
      unique case (idx)
         2'd0:    r = arr[0];
         2'd1:    r = arr[1];
         default: r = arr[2];
      endcase
      return r;
   endfunction

   assign req_chan.ready = !full;
   assign accept  = req_chan.valid && !full;
   assign c       = req_chan.in_byte;
   assign is_cont = (c[7:6] == 2'b10);
   assign is_lead = (c[7:5] == 3'b110) || (c[7:4] == 4'b1110) || (c[7:3] == 5'b11110);

   always_comb begin
      priority if (c[7:5] == 3'b110) begin
         lead_len = 3'd2;
      end else if (c[7:4] == 4'b1110) begin
         lead_len = 3'd3;
      end else begin
         lead_len = 3'd4;
      end
   end

   // Sequence tracking: what is flushed ahead, what is held, what is flushed after.
   always_comb begin
      held_in  = held_ff;
      exp_in   = exp_ff;
      cnt_in   = cnt_ff;
      a_cnt    = 2'd0;
      c_cnt    = 2'd0;
      complete = 1'b0;
      do_fresh = 1'b0;
      raw_one  = 1'b0;
      ascii    = 1'b0;
      if (exp_ff == 3'd0) begin
         do_fresh = 1'b1;
      end else if (is_cont) begin
         if (({1'b0, cnt_ff} + 3'd1 >= exp_ff) || (cnt_ff == 2'd3)) begin
            complete = 1'b1;
            exp_in   = 3'd0;
            cnt_in   = 2'd0;
         end else begin
            for (int i = 0; i < 3; i++) begin
               if (cnt_ff == 2'(i)) begin
                  held_in[i] = c;
               end
            end
            cnt_in = cnt_ff + 2'd1;
         end
      end else begin
         // A broken sequence goes out raw and the byte starts over.
         a_cnt    = cnt_ff;
         exp_in   = 3'd0;
         cnt_in   = 2'd0;
         do_fresh = 1'b1;
      end
      if (do_fresh) begin
         priority if (!c[7]) begin
            ascii = 1'b1;
         end else if (is_lead) begin
            held_in[0] = c;
            cnt_in     = 2'd1;
            exp_in     = lead_len;
         end else begin
            raw_one = 1'b1;
         end
      end
      if (req_chan.end_of_text && exp_in != 3'd0) begin
         c_cnt  = cnt_in;
         exp_in = 3'd0;
         cnt_in = 2'd0;
      end
   end

   always_comb begin
      unique case (exp_ff)
         3'd2:    cp_asm = {10'd0, held_ff[0][4:0], c[5:0]};
         3'd3:    cp_asm = {5'd0, held_ff[0][3:0], held_ff[1][5:0], c[5:0]};
         default: cp_asm = {held_ff[0][2:0], held_ff[1][5:0], held_ff[2][5:0], c[5:0]};
      endcase
   end

   assign cp     = complete ? cp_asm : {13'd0, c};
   assign vis8   = (cp[20:8] == 13'd0) && visible(cp[7:0]);
   assign ctrl   = (cp >= 21'd256) && (cp <= 21'd323);
   assign ctrl_n = cp[6:0];

   always_comb begin
      enc_bytes = '0;
      enc_kinds = {4{KIND_RECODED}};
      enc_cnt   = 3'd1;
      priority if (vis8) begin
         enc_bytes[0] = cp[7:0];
         enc_kinds[0] = KIND_MAPPED;
      end else if (ctrl) begin
         enc_kinds[0] = KIND_MAPPED;
         priority if (ctrl_n < 7'd33) begin
            enc_bytes[0] = {1'b0, ctrl_n};
         end else if (ctrl_n < 7'd67) begin
            enc_bytes[0] = {1'b0, ctrl_n} + 8'd94;
         end else begin
            enc_bytes[0] = 8'hAD;
         end
      end else if (cp <= 21'h7F) begin
         enc_bytes[0] = cp[7:0];
      end else if (cp <= 21'h7FF) begin
         enc_cnt      = 3'd2;
         enc_bytes[0] = 8'hC0 | {3'd0, cp[10:6]};
         enc_bytes[1] = 8'h80 | {2'd0, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
         enc_cnt      = 3'd3;
         enc_bytes[0] = 8'hE0 | {4'd0, cp[15:12]};
         enc_bytes[1] = 8'h80 | {2'd0, cp[11:6]};
         enc_bytes[2] = 8'h80 | {2'd0, cp[5:0]};
      end else begin
         enc_cnt      = 3'd4;
         enc_bytes[0] = 8'hF0 | {5'd0, cp[20:18]};
         enc_bytes[1] = 8'h80 | {2'd0, cp[17:12]};
         enc_bytes[2] = 8'h80 | {2'd0, cp[11:6]};
         enc_bytes[3] = 8'h80 | {2'd0, cp[5:0]};
      end
   end

   always_comb begin
      b_bytes = enc_bytes;
      b_kinds = enc_kinds;
      b_cnt   = 3'd0;
      if (complete || ascii) begin
         b_cnt = enc_cnt;
      end else if (raw_one) begin
         b_cnt      = 3'd1;
         b_bytes[0] = c;
         b_kinds[0] = KIND_RAW;
      end
   end

   // Slot i of the run takes the ahead flush, then the decoded bytes, then the after flush.
   always_comb begin
      logic [2:0] j;
      logic [2:0] k;
      push_data = '0;
      for (int i = 0; i < 4; i++) begin
         j = 3'(i) - {1'b0, a_cnt};
         k = j - b_cnt;
         if (3'(i) < {1'b0, a_cnt}) begin
            push_data.bytes[i] = pick3(held_ff, 2'(i));
            push_data.kinds[i] = KIND_RAW;
         end else if (j < b_cnt) begin
            push_data.bytes[i] = b_bytes[j[1:0]];
            push_data.kinds[i] = b_kinds[j[1:0]];
         end else begin
            push_data.bytes[i] = pick3(held_in, k[1:0]);
            push_data.kinds[i] = KIND_RAW;
         end
      end
      total = {1'b0, a_cnt} + b_cnt + {1'b0, c_cnt};
      push_data.last_idx = 2'(total - 3'd1);
   end

   assign push = accept && (total != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff <= 3'd0;
         cnt_ff <= 2'd0;
      end else if (accept) begin
         exp_ff <= exp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   `BLDEC_ASSERT(a_front_idle_empty, exp_ff == 3'd0, cnt_ff == 2'd0)
   `BLDEC_ASSERT(a_front_open_count, exp_ff != 3'd0, (cnt_ff != 2'd0 && ({1'b0, cnt_ff} < exp_ff)))

endmodule

`default_nettype wire

// File: rtl/core/bldec_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module bldec_fifo #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bldec_pkg::run_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output bldec_pkg::run_type     pop_data,
   output logic                   empty
);
   import bldec_pkg::*;
   `include "byte_level_utf8_text_decoder_unit_macros.svh"

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   run_type            slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   `BLDEC_ASSERT(a_fifo_no_overflow, push, !full)
   `BLDEC_ASSERT(a_fifo_no_underflow, pop, !empty)

endmodule

`default_nettype wire

// File: rtl/core/bldec_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bldec_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bldec_pkg::run_type pop_data,
   input  wire logic              empty,
   output logic                   pop,
   bldec_rsp_if.source            rsp_chan
);
   import bldec_pkg::*;

   run_type    run_ff;
   logic       busy_ff;
   logic       busy_in;
   logic [1:0] idx_ff;
   logic [1:0] idx_in;
   logic       sent;
   logic       at_last;

   assign at_last = (idx_ff == run_ff.last_idx);
   assign sent    = busy_ff && rsp_chan.ready;

   // The next run is loaded as the last word of the current one leaves.
   assign pop = !empty && (!busy_ff || (sent && at_last));

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end else if (sent) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         run_ff <= pop_data;
      end
   end

   assign rsp_chan.valid     = busy_ff;
   assign rsp_chan.out_byte  = run_ff.bytes[idx_ff];
   assign rsp_chan.byte_kind = run_ff.kinds[idx_ff];
   assign rsp_chan.run_last  = at_last;

endmodule

`default_nettype wire

// File: rtl/core/byte_level_utf8_text_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte-level UTF-8 text decoder.
// The req_chan channel carries one text byte per word with an end_of_text
// flag on the final byte. The rsp_chan channel returns restored bytes, each
// tagged with its kind (mapped, re-encoded or raw) and run_last on the final
// word caused by one input word; a byte that only opens or extends a
// sequence causes no word.
// The front stage classifies each byte and builds its whole run of up to four
// words in the cycle it is accepted; the run waits in a QUEUE_DEPTH-entry
// queue, and the back stage sends it one word per cycle while the receiver is ready, from a register.
// The first word of a run is offered from the back stage register, after
// the run has passed a queue slot. Input is taken every cycle while the
// queue has room, so one byte per cycle is sustained while runs average one
// word, and the single output word per cycle sets the long-term rate.
// If the receiver stalls, the current word holds and input stops only once
// the queue is full. Reset closes any open sequence and empties the queue.
module byte_level_utf8_text_decoder_unit #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bldec_req_if.sink  req_chan,
   bldec_rsp_if.source rsp_chan
);
   import bldec_pkg::*;

   run_type push_data;
   run_type pop_data;
   logic    push;
   logic    pop;
   logic    full;
   logic    empty;

   bldec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .push_data (push_data),
      .push      (push),
      .full      (full)
   );

   bldec_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   bldec_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_data (pop_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// File: tb/byte_level_utf8_text_decoder_unit_tb.sv
`timescale 1ns / 1ps

module byte_level_utf8_text_decoder_unit_tb;
   import bldec_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 286;
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [7:0] value;
      logic [1:0] kind;
      logic       last;
   } restored_word_type;

   // Tracks the open UTF-8 sequence and queues the words each text byte must produce.
   class restore_scoreboard;
      logic [7:0]        held [3];
      logic [2:0]        seq_len = 3'd0;
      logic [1:0]        held_cnt = 2'd0;
      int                run_start = 0;
      int                errors = 0;
      restored_word_type expected_words[$];

      function int outstanding();
         return expected_words.size();
      endfunction

      function void push_word(logic [7:0] value, logic [1:0] kind);
         restored_word_type w;
         if (expected_words.size() - run_start >= RUN_SLOTS) return;
         w.value = value;
         w.kind = kind;
         w.last = 1'b0;
         expected_words.insert(expected_words.size(), w);
      endfunction

      function bit visible_byte(logic [7:0] b);
         return (b >= 8'h21 && b <= 8'h7E) || (b >= 8'hA1 && b <= 8'hAC) || (b >= 8'hAE);
      endfunction

      function void restore_code_point(logic [20:0] cp);
         logic [6:0] n;
         if (cp <= 21'hFF && visible_byte(cp[7:0])) begin
            push_word(cp[7:0], KIND_MAPPED);
         end else if (cp >= 21'd256 && cp <= 21'd323) begin
            // Code points above 255 stand for the non-visible bytes in ascending order.
            n = 7'(cp - 21'd256);
            if (n < 7'd33) push_word({1'b0, n}, KIND_MAPPED);
            else if (n < 7'd67) push_word(8'({1'b0, n} + 8'd94), KIND_MAPPED);
            else push_word(8'hAD, KIND_MAPPED);
         end else if (cp <= 21'h7F) begin
            push_word(cp[7:0], KIND_RECODED);
         end else if (cp <= 21'h7FF) begin
            push_word({3'b110, cp[10:6]}, KIND_RECODED);
            push_word({2'b10, cp[5:0]}, KIND_RECODED);
         end else if (cp <= 21'hFFFF) begin
            push_word({4'b1110, cp[15:12]}, KIND_RECODED);
            push_word({2'b10, cp[11:6]}, KIND_RECODED);
            push_word({2'b10, cp[5:0]}, KIND_RECODED);
         end else begin
            push_word({5'b11110, cp[20:18]}, KIND_RECODED);
            push_word({2'b10, cp[17:12]}, KIND_RECODED);
            push_word({2'b10, cp[11:6]}, KIND_RECODED);
            push_word({2'b10, cp[5:0]}, KIND_RECODED);
         end
      endfunction

      function void flush_held_raw();
         int i;
         for (i = 0; i < held_cnt; i++) push_word(held[i], KIND_RAW);
         held_cnt = 2'd0;
         seq_len = 3'd0;
      endfunction

      function void parse_byte(logic [7:0] c);
         int pass;
         int i;
         logic [20:0] cp;
         // A bad continuation closes the open sequence and the byte is parsed once more.
         for (pass = 0; pass < 2; pass++) begin
            if (seq_len == 3'd0) begin
               if (!c[7]) begin
                  restore_code_point({13'd0, c});
               end else if (c[7:5] == 3'b110 || c[7:4] == 4'b1110 || c[7:3] == 5'b11110) begin
                  held[0] = c;
                  held_cnt = 2'd1;
                  seq_len = (c[7:5] == 3'b110) ? 3'd2 : (c[7:4] == 4'b1110) ? 3'd3 : 3'd4;
               end else begin
                  push_word(c, KIND_RAW);
               end
               return;
            end
            if (c[7:6] == 2'b10) begin
               if (held_cnt + 1 >= seq_len || held_cnt >= 3) begin
                  cp = (seq_len == 3'd2) ? {16'd0, held[0][4:0]}
                     : (seq_len == 3'd3) ? {17'd0, held[0][3:0]} : {18'd0, held[0][2:0]};
                  for (i = 1; i < held_cnt; i++) cp = (cp << 6) | {15'd0, held[i][5:0]};
                  cp = (cp << 6) | {15'd0, c[5:0]};
                  held_cnt = 2'd0;
                  seq_len = 3'd0;
                  restore_code_point(cp);
               end else begin
                  held[held_cnt] = c;
                  held_cnt++;
               end
               return;
            end
            flush_held_raw();
         end
      endfunction

      function void note_text_byte(logic [7:0] c, logic eot);
         run_start = expected_words.size();
         parse_byte(c);
         if (eot && seq_len != 3'd0) flush_held_raw();
         if (expected_words.size() > run_start)
            expected_words[expected_words.size() - 1].last = 1'b1;
      endfunction

      function void check_word(logic [7:0] value, logic [1:0] kind, logic last);
         restored_word_type w;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h kind %0d last %0b",
                     $time, value, kind, last);
            errors++;
            return;
         end
         w = expected_words.pop_front();
         if (value !== w.value) begin
            $display("%0t: out_byte expected %h actual %h", $time, w.value, value);
            errors++;
         end
         if (kind !== w.kind) begin
            $display("%0t: byte_kind expected %0d actual %0d", $time, w.kind, kind);
            errors++;
         end
         if (last !== w.last) begin
            $display("%0t: run_last expected %0b actual %0b", $time, w.last, last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit calm_tail = 1'b0;
   int unsigned sent_count = 0;
   int unsigned cycle_count = 0;
   restore_scoreboard sb = new;

   // Bit 8 carries end_of_text.
   logic [8:0] opening_words [0:23] = '{
      9'h000, 9'h07F, 9'h021, 9'h0FF, 9'h080,
      9'h0C2, 9'h0A1, 9'h0C2, 9'h0AD, 9'h0C4, 9'h080, 9'h0C5, 9'h083,
      9'h0E2, 9'h082, 9'h0AC, 9'h0F0, 9'h09F, 9'h098, 9'h080,
      9'h0C3, 9'h041, 9'h0E2, 9'h182
   };

   bldec_req_if req_chan ();
   bldec_rsp_if rsp_chan ();

   byte_level_utf8_text_decoder_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_text_byte(req_chan.in_byte, req_chan.end_of_text);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_word(rsp_chan.out_byte, rsp_chan.byte_kind, rsp_chan.run_last);
      end
   end

   initial begin : result_drain
      int unsigned stall;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm_tail && $urandom_range(0, 15) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall = $urandom_range(1, 13);
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_word(input logic [7:0] b, input logic eot);
      int unsigned gap;
      if (!calm_tail && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         req_chan.in_byte <= 8'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.in_byte <= b;
      req_chan.end_of_text <= eot;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Mostly well-formed UTF-8 with random payload; the rest is truncated
   // sequences and arbitrary bytes.
   task automatic send_random_sequence();
      logic [7:0]  burst[$];
      logic [10:0] cp;
      int unsigned pick;
      int unsigned seq_bytes;
      int unsigned conts;
      int          i;
      logic        eot_last;
      pick = $urandom_range(0, 99);
      eot_last = ($urandom_range(0, 9) == 0);
      if (pick < 25) begin
         burst.insert(burst.size(), 8'($urandom_range(0, 127)));
      end else if (pick < 45) begin
         burst.insert(burst.size(), 8'($urandom_range(8'hC0, 8'hDF)));
         burst.insert(burst.size(), 8'($urandom_range(8'h80, 8'hBF)));
      end else if (pick < 55) begin
         cp = 11'(256 + $urandom_range(0, 70));
         burst.insert(burst.size(), {3'b110, cp[10:6]});
         burst.insert(burst.size(), {2'b10, cp[5:0]});
      end else if (pick < 70) begin
         burst.insert(burst.size(), 8'($urandom_range(8'hE0, 8'hEF)));
         repeat (2) burst.insert(burst.size(), 8'($urandom_range(8'h80, 8'hBF)));
      end else if (pick < 80) begin
         burst.insert(burst.size(), 8'($urandom_range(8'hF0, 8'hF7)));
         repeat (3) burst.insert(burst.size(), 8'($urandom_range(8'h80, 8'hBF)));
      end else if (pick < 90) begin
         seq_bytes = $urandom_range(2, 4);
         burst.insert(burst.size(), (seq_bytes == 2) ? 8'($urandom_range(8'hC0, 8'hDF))
                                  : (seq_bytes == 3) ? 8'($urandom_range(8'hE0, 8'hEF))
                                  : 8'($urandom_range(8'hF0, 8'hF7)));
         conts = $urandom_range(0, seq_bytes - 2);
         repeat (conts) burst.insert(burst.size(), 8'($urandom_range(8'h80, 8'hBF)));
         eot_last = 1'($urandom_range(0, 1));
      end else begin
         burst.insert(burst.size(), 8'($urandom));
      end
      for (i = 0; i < burst.size(); i++)
         send_word(burst[i], eot_last && (i == burst.size() - 1));
   endtask

   initial begin : stimulus
      int  i;
      bit  drained_mid;
      drained_mid = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.in_byte = 8'h00;
      req_chan.end_of_text = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < 24; i++) send_word(opening_words[i][7:0], opening_words[i][8]);
      wait_for_drain();

      while (sent_count < 24 + RANDOM_ITEMS) begin
         if (!drained_mid && sent_count >= 24 + RANDOM_ITEMS / 2) begin
            wait_for_drain();
            drained_mid = 1'b1;
         end
         if (sent_count >= 24 + (RANDOM_ITEMS * 85) / 100) calm_tail = 1'b1;
         send_random_sequence();
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
